/* rtl/ini_line_scanner_assert.svh */
// ----------------------------------------------------------------------------
// ini_line_scanner assertion macros
// Concurrent assertion wrappers on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INI_LINE_SCANNER_ASSERT_SVH
`define INI_LINE_SCANNER_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ILS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ini_line_scanner: same-cycle check failed");

// next-cycle implication
`define ILS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ini_line_scanner: next-cycle check failed");

`else

`define ILS_ASSERT_IMPL(label, ante, cons)
`define ILS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/ils_pkg.sv */
// ----------------------------------------------------------------------------
// ils_pkg
// Types and character codes shared by the line scanner modules.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int unsigned OFS_W  = 16;
  localparam int unsigned BYTE_W = 8;

  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;

  typedef enum logic [2:0] {
    MODE_SKIP,
    MODE_AFTERCOM,
    MODE_COMMENT,
    MODE_BODY,
    MODE_ESC,
    MODE_ESCTAIL
  } ils_mode_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_text;
  } ils_item_t;

  typedef struct packed {
    logic [OFS_W-1:0]  line_start;
    logic [OFS_W-1:0]  line_length;
    logic              has_equals;
    logic [OFS_W-1:0]  equals_offset;
    logic [BYTE_W-1:0] lead_byte;
    logic              stream_end;
    logic              offset_overflow;
  } ils_line_t;

endpackage

/* rtl/ils_in_if.sv */
// ----------------------------------------------------------------------------
// ils_in_if
// Byte request channel: valid/ready handshake with the text byte payload.
// ----------------------------------------------------------------------------
interface ils_in_if;
  logic                         valid;
  logic                         ready;
  logic [ils_pkg::BYTE_W-1:0]   data_byte;
  logic                         end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

/* rtl/ils_out_if.sv */
// ----------------------------------------------------------------------------
// ils_out_if
// Line result channel: valid/ready handshake with one line descriptor.
// ----------------------------------------------------------------------------
interface ils_out_if;
  logic                         valid;
  logic                         ready;
  logic [ils_pkg::OFS_W-1:0]    line_start;
  logic [ils_pkg::OFS_W-1:0]    line_length;
  logic                         has_equals;
  logic [ils_pkg::OFS_W-1:0]    equals_offset;
  logic [ils_pkg::BYTE_W-1:0]   lead_byte;
  logic                         stream_end;
  logic                         offset_overflow;

  modport source (
    output valid, output line_start, output line_length, output has_equals,
    output equals_offset, output lead_byte, output stream_end,
    output offset_overflow, input ready
  );
  modport sink (
    input valid, input line_start, input line_length, input has_equals,
    input equals_offset, input lead_byte, input stream_end,
    input offset_overflow, output ready
  );
endinterface

/* rtl/ils_in_stage.sv */
// ----------------------------------------------------------------------------
// ils_in_stage
// Input register: holds one byte request until the scan core takes it.
// ----------------------------------------------------------------------------
module ils_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  ils_in_if.sink             in_ch,
  input  logic               take,
  output logic               item_valid,
  output ils_pkg::ils_item_t item
);
  import ils_pkg::*;

  logic      valid_r;
  ils_item_t item_r;

  assign in_ch.ready = !valid_r || take;
  assign item_valid  = valid_r;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.data_byte   <= in_ch.data_byte;
      item_r.end_of_text <= in_ch.end_of_text;
    end
  end

endmodule

/* rtl/ils_core.sv */
// ----------------------------------------------------------------------------
// ils_core
// Scan state and the single-pass byte update that closes lines.
// ----------------------------------------------------------------------------
`include "ini_line_scanner_assert.svh"

module ils_core #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  ils_pkg::ils_item_t item,
  input  logic               adv,
  output logic               res_valid,
  output ils_pkg::ils_line_t res
);
  import ils_pkg::*;

  localparam int unsigned OW = (OFFSET_BITS < OFS_W) ? OFFSET_BITS : OFS_W;
  localparam logic [OW-1:0] LIM = '1;

  ils_mode_t         mode_r, mode_nxt;
  logic [OW-1:0]     off_r, start_r, feq_r;
  logic [OW-1:0]     off_nxt, start_nxt, feq_nxt;
  logic              eq_r, q_r, esc_cr_r, sat_r;
  logic              eq_nxt, q_nxt, esc_cr_nxt, sat_nxt;
  logic [BYTE_W-1:0] lead_r, lead_nxt;

  logic [BYTE_W-1:0] b;
  logic              last;
  logic              is_eol, is_blank, is_hash, is_eq, is_quote, is_bsl;
  logic              at_lim, sat_cur, complement;
  logic              start_line, use_body, term, upd_eq, emit_end;
  logic [OW-1:0]     pos, off_inc;
  logic [OW-1:0]     ctx_start, ctx_feq, line_feq, end_pos;
  logic [BYTE_W-1:0] ctx_lead;
  logic              ctx_eq, ctx_q, line_eq, line_q;
  logic [OW:0]       diff;
  logic [OW-1:0]     len;

  assign b    = item.data_byte;
  assign last = item.end_of_text;

  assign is_eol   = (b == CH_LF) || (b == CH_CR);
  assign is_blank = (b == CH_TAB) || (b == CH_SP);
  assign is_hash  = (b == CH_HASH);
  assign is_eq    = (b == CH_EQ);
  assign is_quote = (b == CH_QUOTE);
  assign is_bsl   = (b == CH_BSL);

  assign at_lim  = (off_r == LIM);
  assign sat_cur = sat_r || at_lim;
  assign pos     = off_r;
  assign off_inc = at_lim ? off_r : off_r + 1'b1;

  assign complement = esc_cr_r ? (b == CH_LF) : (b == CH_CR);

  assign start_line = ((mode_r == MODE_SKIP) && !is_eol && !is_blank && !is_hash) ||
                      ((mode_r == MODE_AFTERCOM) && !is_eol && !is_hash);
  assign use_body   = start_line || (mode_r == MODE_BODY) ||
                      ((mode_r == MODE_ESCTAIL) && !complement);

  assign ctx_start = start_line ? pos : start_r;
  assign ctx_lead  = start_line ? b : lead_r;
  assign ctx_eq    = start_line ? 1'b0 : eq_r;
  assign ctx_feq   = start_line ? '0 : feq_r;
  assign ctx_q     = start_line ? 1'b0 : q_r;

  assign term     = use_body && !ctx_q && (is_eol || is_hash);
  assign upd_eq   = use_body && is_eq && !ctx_q && !ctx_eq;
  assign line_eq  = ctx_eq || upd_eq;
  assign line_feq = upd_eq ? pos : ctx_feq;
  assign line_q   = ctx_q ^ (use_body && is_quote);

  // next state
  always_comb begin
    mode_nxt   = mode_r;
    esc_cr_nxt = esc_cr_r;
    unique case (mode_r)
      MODE_SKIP, MODE_AFTERCOM: begin
        if (is_hash) begin
          mode_nxt = MODE_COMMENT;
        end
      end
      MODE_COMMENT: begin
        if (is_eol) begin
          mode_nxt = MODE_AFTERCOM;
        end
      end
      MODE_BODY: begin
        mode_nxt = MODE_BODY;
      end
      MODE_ESC: begin
        if (is_eol) begin
          esc_cr_nxt = (b == CH_CR);
          mode_nxt   = MODE_ESCTAIL;
        end else begin
          mode_nxt = MODE_BODY;
        end
      end
      MODE_ESCTAIL: begin
        mode_nxt   = MODE_BODY;
        esc_cr_nxt = 1'b0;
      end
      default: begin
        mode_nxt = MODE_SKIP;
      end
    endcase
    if (use_body) begin
      if (term) begin
        mode_nxt   = is_hash ? MODE_COMMENT : MODE_SKIP;
        esc_cr_nxt = 1'b0;
      end else if (is_bsl) begin
        mode_nxt = MODE_ESC;
      end else begin
        mode_nxt = MODE_BODY;
      end
    end
    eq_nxt    = term ? 1'b0 : line_eq;
    q_nxt     = term ? 1'b0 : line_q;
    feq_nxt   = term ? '0 : line_feq;
    start_nxt = ctx_start;
    lead_nxt  = ctx_lead;
    off_nxt   = off_inc;
    sat_nxt   = sat_cur;
  end

  // result
  always_comb begin
    emit_end = last && !term &&
               ((mode_nxt == MODE_BODY) || (mode_nxt == MODE_ESC) ||
                (mode_nxt == MODE_ESCTAIL));
    end_pos  = term ? pos : off_inc;
    diff     = {1'b0, end_pos} - {1'b0, ctx_start};
    len      = (diff[OW] || (diff[OW-1:0] == '0)) ? OW'(1) : diff[OW-1:0];

    res_valid           = item_valid && (term || emit_end);
    res.line_start      = OFS_W'(ctx_start);
    res.line_length     = OFS_W'(len);
    res.has_equals      = line_eq;
    res.equals_offset   = line_eq ? OFS_W'(line_feq) : '0;
    res.lead_byte       = ctx_lead;
    res.stream_end      = !term;
    res.offset_overflow = sat_cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (adv && last)) begin
      mode_r   <= MODE_SKIP;
      off_r    <= '0;
      start_r  <= '0;
      feq_r    <= '0;
      eq_r     <= 1'b0;
      q_r      <= 1'b0;
      lead_r   <= '0;
      esc_cr_r <= 1'b0;
      sat_r    <= 1'b0;
    end else if (adv) begin
      mode_r   <= mode_nxt;
      off_r    <= off_nxt;
      start_r  <= start_nxt;
      feq_r    <= feq_nxt;
      eq_r     <= eq_nxt;
      q_r      <= q_nxt;
      lead_r   <= lead_nxt;
      esc_cr_r <= esc_cr_nxt;
      sat_r    <= sat_nxt;
    end
  end

  `ILS_ASSERT_NEXT(a_end_clears_scan, adv && last, (mode_r == MODE_SKIP) && (off_r == '0))
  `ILS_ASSERT_IMPL(a_len_nonzero, res_valid, res.line_length != '0)
  `ILS_ASSERT_IMPL(a_no_eq_zero_ofs, res_valid && !res.has_equals, res.equals_offset == '0)
  `ILS_ASSERT_IMPL(a_esc_cr_in_tail, esc_cr_r, mode_r == MODE_ESCTAIL)
  `ILS_ASSERT_IMPL(a_quote_in_line, q_r, (mode_r == MODE_BODY) || (mode_r == MODE_ESC) || (mode_r == MODE_ESCTAIL))

endmodule

/* rtl/ils_out_stage.sv */
// ----------------------------------------------------------------------------
// ils_out_stage
// Result register: holds one line descriptor until the sink takes it.
// ----------------------------------------------------------------------------
module ils_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  ils_out_if.source          out_ch,
  input  logic               load,
  input  ils_pkg::ils_line_t res,
  output logic               free
);
  import ils_pkg::*;

  logic      valid_r;
  ils_line_t line_r;

  assign free = !valid_r || out_ch.ready;

  assign out_ch.valid           = valid_r;
  assign out_ch.line_start      = line_r.line_start;
  assign out_ch.line_length     = line_r.line_length;
  assign out_ch.has_equals      = line_r.has_equals;
  assign out_ch.equals_offset   = line_r.equals_offset;
  assign out_ch.lead_byte       = line_r.lead_byte;
  assign out_ch.stream_end      = line_r.stream_end;
  assign out_ch.offset_overflow = line_r.offset_overflow;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      line_r <= res;
    end
  end

endmodule

/* rtl/ini_line_scanner.sv */
// ----------------------------------------------------------------------------
// ini_line_scanner
// Marks the logical lines of an INI text streamed one byte per request.
//
//   channel  dir  payload
//   in_ch    in   data_byte, end_of_text
//   out_ch   out  line_start, line_length, has_equals, equals_offset,
//                 lead_byte, stream_end, offset_overflow
//
// One byte per cycle sustained while out_ch is not stalled; a byte's line
// result passes through the input register and then the result register.
// The scan core updates its state in a single pass as the byte leaves the
// input register. Synchronous reset clears both registers' valid flags and the scan state.
// A stall on out_ch holds the result; the input register still takes one byte.
// ----------------------------------------------------------------------------
module ini_line_scanner #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  ils_in_if.sink    in_ch,
  ils_out_if.source out_ch
);
  import ils_pkg::*;

  logic      item_valid;
  ils_item_t item;
  logic      res_valid;
  ils_line_t res;
  logic      free;
  logic      fire;

  assign fire = item_valid && free;

  ils_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  ils_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .adv        (fire),
    .res_valid  (res_valid),
    .res        (res)
  );

  ils_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .out_ch (out_ch),
    .load   (fire && res_valid),
    .res    (res),
    .free   (free)
  );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: ini_line_scanner regression
// Streams INI-style text through the scanner one byte per request, with random
// gaps and stalls on both channels. It tracks the line state of every byte
// accepted and compares each line descriptor with the one it works out.
// It covers directed corner cases, random streams and back-pressure.
// ----------------------------------------------------------------------------
import ils_pkg::*;

typedef logic [BYTE_W-1:0] octet_t;

class ini_line_ledger;
  ils_mode_t    mode;
  int unsigned  limit, offset, line_start, eq_pos;
  bit           eq_seen, in_quote, esc_cr, sat;
  octet_t       lead;
  ils_line_t    due_lines[$];
  int unsigned  errors, shown;

  function new(int unsigned ofs_limit);
    limit  = ofs_limit;
    errors = 0;
    shown  = 0;
    restart();
  endfunction

  function bit is_eol(octet_t b);
    return b == CH_LF || b == CH_CR;
  endfunction

  function void clear_line();
    eq_pos   = 0;
    eq_seen  = 0;
    in_quote = 0;
    esc_cr   = 0;
  endfunction

  function void restart();
    mode       = MODE_SKIP;
    offset     = 0;
    line_start = 0;
    lead       = '0;
    sat        = 0;
    clear_line();
  endfunction

  function void close_line(int unsigned stop_pos, bit at_end);
    ils_line_t   l;
    int unsigned len;
    len = stop_pos - line_start;
    if (stop_pos < line_start || len == 0) len = 1;
    l.line_start      = OFS_W'(line_start);
    l.line_length     = OFS_W'(len);
    l.has_equals      = eq_seen;
    l.equals_offset   = eq_seen ? OFS_W'(eq_pos) : '0;
    l.lead_byte       = lead;
    l.stream_end      = at_end;
    l.offset_overflow = sat;
    due_lines.push_back(l);
    clear_line();
  endfunction

  function bit body_byte(octet_t b, int unsigned pos);
    if (is_eol(b)) begin
      if (!in_quote) begin
        close_line(pos, 1'b0);
        mode = MODE_SKIP;
        return 1;
      end
    end else if (b == CH_HASH) begin
      if (!in_quote) begin
        close_line(pos, 1'b0);
        mode = MODE_COMMENT;
        return 1;
      end
    end else if (b == CH_EQ) begin
      if (!in_quote && !eq_seen) begin
        eq_seen = 1;
        eq_pos  = pos;
      end
    end else if (b == CH_QUOTE) begin
      in_quote = !in_quote;
    end else if (b == CH_BSL) begin
      mode = MODE_ESC;
    end
    return 0;
  endfunction

  function void take_byte(ils_item_t it);
    octet_t      b;
    int unsigned pos;
    bit          closed;
    b      = it.data_byte;
    closed = 0;
    if (offset >= limit) begin
      offset = limit;
      sat    = 1;
    end
    pos = offset;
    if (offset < limit) offset++;
    case (mode)
      MODE_SKIP, MODE_AFTERCOM: begin
        if (b == CH_HASH) begin
          mode = MODE_COMMENT;
        end else if (!is_eol(b) &&
                     !(mode == MODE_SKIP && (b == CH_TAB || b == CH_SP))) begin
          clear_line();
          line_start = pos;
          lead       = b;
          mode       = MODE_BODY;
          closed     = body_byte(b, pos);
        end
      end
      MODE_COMMENT: begin
        if (is_eol(b)) mode = MODE_AFTERCOM;
      end
      MODE_BODY: begin
        closed = body_byte(b, pos);
      end
      MODE_ESC: begin
        if (is_eol(b)) begin
          esc_cr = (b == CH_CR);
          mode   = MODE_ESCTAIL;
        end else begin
          mode = MODE_BODY;
        end
      end
      MODE_ESCTAIL: begin
        mode = MODE_BODY;
        if (!(esc_cr ? b == CH_LF : b == CH_CR)) closed = body_byte(b, pos);
        esc_cr = 0;
      end
      default: begin
        mode = MODE_SKIP;
      end
    endcase
    if (it.end_of_text) begin
      if (!closed && mode inside {MODE_BODY, MODE_ESC, MODE_ESCTAIL})
        close_line((pos < limit) ? pos + 1 : limit, 1'b1);
      restart();
    end
  endfunction

  function string show(ils_line_t l);
    return $sformatf("start=%0d len=%0d eq=%0b@%0d lead=%h end=%0b ovf=%0b",
                     l.line_start, l.line_length, l.has_equals, l.equals_offset,
                     l.lead_byte, l.stream_end, l.offset_overflow);
  endfunction

  function void note_error(string msg);
    errors++;
    if (shown < 10) begin
      shown++;
      $display("%0t: %s", $time, msg);
    end
  endfunction

  function void match_line(ils_line_t got);
    ils_line_t want;
    if (due_lines.size() == 0) begin
      note_error($sformatf("line with no request waiting: %s", show(got)));
      return;
    end
    want = due_lines.pop_front();
    if (got.line_start !== want.line_start || got.line_length !== want.line_length ||
        got.has_equals !== want.has_equals || got.equals_offset !== want.equals_offset ||
        got.lead_byte !== want.lead_byte || got.stream_end !== want.stream_end ||
        got.offset_overflow !== want.offset_overflow)
      note_error($sformatf("line mismatch\n  expected %s\n  actual   %s",
                           show(want), show(got)));
  endfunction
endclass

module tb_top;
  localparam int unsigned OFFSET_BITS  = 16;
  localparam int unsigned OFS_LIMIT    = (OFFSET_BITS >= 16) ? 32'hFFFF
                                         : (32'd1 << OFFSET_BITS) - 1;
  localparam int unsigned ITEM_TARGET  = 1550;
  localparam int unsigned PRESS_CYCLES = 120;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic clk;
  logic rst_n;

  ils_in_if  in_ch ();
  ils_out_if out_ch ();

  ini_line_scanner #(.OFFSET_BITS(OFFSET_BITS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ini_line_ledger ledger;
  ils_item_t      seen_byte;
  ils_line_t      seen_line;
  int unsigned    in_idle_pct, out_idle_pct, sent_bytes;
  bit             press_req;

  assign seen_byte = {in_ch.data_byte, in_ch.end_of_text};
  assign seen_line = {out_ch.line_start, out_ch.line_length, out_ch.has_equals,
                      out_ch.equals_offset, out_ch.lead_byte, out_ch.stream_end,
                      out_ch.offset_overflow};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned gap_len(int unsigned pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 4))
      0, 1: return 0;
      2: return 10;
      3: return 30;
      default: return 60;
    endcase
  endfunction

  function automatic octet_t text_char();
    case ($urandom_range(0, 9))
      0: return CH_SP;
      1: return octet_t'(8'h30 + $urandom_range(0, 9));
      default: return octet_t'(8'h61 + $urandom_range(0, 25));
    endcase
  endfunction

  // append one line of INI text, terminator included, or random bytes with no terminator when noisy
  function automatic void make_line(ref octet_t q[$], input bit noisy);
    int unsigned kind;
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0: q.push_back(CH_SP);
        1: q.push_back(CH_TAB);
        2: q.push_back(CH_CR);
        default: q.push_back(CH_LF);
      endcase
    end
    kind = $urandom_range(0, 99);
    if (noisy && kind < 12) begin
      repeat ($urandom_range(1, 8)) q.push_back(octet_t'($urandom));
      return;
    end
    if (kind < 27) begin
      q.push_back(CH_HASH);
      repeat ($urandom_range(0, 10)) q.push_back(text_char());
    end else if (kind < 40) begin
      q.push_back("[");
      repeat ($urandom_range(1, 6)) q.push_back(text_char());
      q.push_back("]");
    end else begin
      repeat ($urandom_range(1, 6)) q.push_back(text_char());
      if ($urandom_range(0, 5) != 0) q.push_back(CH_EQ);
      repeat ($urandom_range(0, 8)) begin
        case ($urandom_range(0, 9))
          0: q.push_back(CH_EQ);
          1: begin
            q.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 4)) begin
              case ($urandom_range(0, 5))
                0: q.push_back(CH_EQ);
                1: q.push_back(CH_HASH);
                2: q.push_back(CH_CR);
                3: q.push_back(CH_LF);
                default: q.push_back(text_char());
              endcase
            end
            q.push_back(CH_QUOTE);
          end
          2: begin
            q.push_back(CH_BSL);
            case ($urandom_range(0, 6))
              0: begin
                q.push_back(CH_CR);
                q.push_back(CH_LF);
              end
              1: begin
                q.push_back(CH_LF);
                q.push_back(CH_CR);
              end
              2: q.push_back(CH_CR);
              3: q.push_back(CH_LF);
              4: q.push_back(CH_HASH);
              5: q.push_back(CH_BSL);
              default: q.push_back(text_char());
            endcase
          end
          default: q.push_back(text_char());
        endcase
      end
    end
    case ($urandom_range(0, 5))
      0: q.push_back(CH_CR);
      1: begin
        q.push_back(CH_CR);
        q.push_back(CH_LF);
      end
      2: begin
        q.push_back(CH_HASH);
        repeat ($urandom_range(0, 6)) q.push_back(text_char());
        q.push_back(CH_LF);
      end
      default: q.push_back(CH_LF);
    endcase
  endfunction

  task automatic send_byte(input octet_t b, input bit fin);
    int unsigned gap;
    gap = gap_len(in_idle_pct);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.end_of_text <= fin;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic send_stream(ref octet_t q[$]);
    for (int i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
  endtask

  // sample both channels on the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ledger.match_line(seen_line);
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ledger.take_byte(seen_byte);
    end
  end

  initial begin : receiver
    int unsigned hold;
    hold         = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0 && press_req) begin
        hold      = PRESS_CYCLES;
        press_req = 0;
      end else if (hold == 0) begin
        hold = gap_len(out_idle_pct);
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    octet_t      text[$];
    int unsigned target;
    bit          pressed_again;
    ledger            = new(OFS_LIMIT);
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = '0;
    in_ch.end_of_text = 1'b0;
    rst_n             = 1'b0;
    in_idle_pct       = 0;
    out_idle_pct      = 0;
    sent_bytes        = 0;
    press_req         = 0;
    pressed_again     = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // blanks, comment, blank after comment, quoted terminators, both escapes,
    // terminator on the last byte
    text = '{CH_SP, CH_TAB, CH_HASH, "c", CH_LF, CH_LF, CH_SP, "k", CH_EQ, CH_QUOTE,
             CH_HASH, CH_EQ, CH_QUOTE, CH_BSL, CH_CR, CH_LF, "v", CH_BSL, CH_LF,
             CH_CR, CH_EQ, CH_CR};
    send_stream(text);
    // byte extremes, mid-line comment, line closed by end of text in escape
    text = '{8'hFF, 8'h00, CH_HASH, "z", CH_LF, CH_CR, "[", CH_BSL};
    send_stream(text);

    // hold the receiver off while short lines keep coming
    text.delete();
    repeat (40) text = {text, "k", CH_EQ, "1", CH_LF};
    press_req = 1;
    send_stream(text);

    while (sent_bytes < ITEM_TARGET) begin
      in_idle_pct  = pick_pct();
      out_idle_pct = pick_pct();
      if (!pressed_again && sent_bytes > ITEM_TARGET / 2) begin
        press_req     = 1;
        pressed_again = 1;
      end
      text.delete();
      target = $urandom_range(10, 120);
      if ($urandom_range(0, 19) == 0) begin
        repeat (target) text.push_back(octet_t'($urandom));
      end else begin
        while (text.size() < target) make_line(text, 1'b1);
      end
      send_stream(text);
    end
    in_ch.valid <= 1'b0;

    while (ledger.due_lines.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.due_lines.size() != 0)
      ledger.note_error($sformatf("%0d lines never produced", ledger.due_lines.size()));
    if (ledger.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

/* files.f */
+incdir+rtl
rtl/ils_pkg.sv
rtl/ils_in_if.sv
rtl/ils_out_if.sv
rtl/ils_in_stage.sv
rtl/ils_core.sv
rtl/ils_out_stage.sv
rtl/ini_line_scanner.sv
verif/tb_top.sv
